// File: sv/trem_pkg.sv
`timescale 1ns / 1ps

package trem_pkg;

    localparam int DIV_W  = 64;
    localparam int SEC_W  = 32;
    localparam int PC_W   = 3;
    localparam int CFG_IW = 2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] REG_TOTAL_SIZE    = 2'd0;
    localparam logic [CFG_IW-1:0] REG_RESUME_OFFSET = 2'd1;
    localparam logic [CFG_IW-1:0] REG_START_SECOND  = 2'd2;

    typedef enum logic [2:0] {
        OP_FETCH,
        OP_TEST,
        OP_DIV,
        OP_FINISH,
        OP_COMMIT,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        DVD_MOVED,
        DVD_LEFT,
        DVD_DELTA
    } dvd_sel_t;

    typedef enum logic [1:0] {
        DVS_START,
        DVS_AVG,
        DVS_CHECK
    } dvs_sel_t;

    typedef enum logic [1:0] {
        DST_TMP,
        DST_ETA,
        DST_RATE
    } dst_t;

    typedef enum logic [1:0] {
        J_NONE,
        J_ALWAYS,
        J_NOUPD,
        J_FIN
    } jcond_t;

    typedef struct packed {
        op_t               op;
        dvd_sel_t          dvd;
        dvs_sel_t          dvs;
        dst_t              dst;
        jcond_t            jcond;
        logic [PC_W-1:0]   jaddr;
    } cw_t;

    typedef struct packed {
        logic step_done;
        logic no_upd;
        logic fin;
    } seq_status_t;

    localparam logic [PC_W-1:0] PC_FETCH  = 3'd0;
    localparam logic [PC_W-1:0] PC_FINISH = 3'd5;
    localparam logic [PC_W-1:0] PC_COMMIT = 3'd6;
    localparam logic [PC_W-1:0] PC_EMIT   = 3'd7;

    // microprogram
    function automatic cw_t trem_rom(input logic [PC_W-1:0] pc);
        cw_t cw;
        cw = '{OP_FETCH, DVD_MOVED, DVS_START, DST_TMP, J_NONE, PC_FETCH};
        case (pc)
            3'd0: cw = '{OP_FETCH,  DVD_MOVED, DVS_START, DST_TMP,  J_NONE,   PC_FETCH};
            3'd1: cw = '{OP_TEST,   DVD_MOVED, DVS_START, DST_TMP,  J_NOUPD,  PC_EMIT};
            3'd2: cw = '{OP_DIV,    DVD_MOVED, DVS_START, DST_TMP,  J_FIN,    PC_FINISH};
            3'd3: cw = '{OP_DIV,    DVD_LEFT,  DVS_AVG,   DST_ETA,  J_NONE,   PC_FETCH};
            3'd4: cw = '{OP_DIV,    DVD_DELTA, DVS_CHECK, DST_RATE, J_ALWAYS, PC_COMMIT};
            3'd5: cw = '{OP_FINISH, DVD_MOVED, DVS_START, DST_TMP,  J_NONE,   PC_FETCH};
            3'd6: cw = '{OP_COMMIT, DVD_MOVED, DVS_START, DST_TMP,  J_NONE,   PC_FETCH};
            3'd7: cw = '{OP_EMIT,   DVD_MOVED, DVS_START, DST_TMP,  J_ALWAYS, PC_FETCH};
            default: cw = '{OP_FETCH, DVD_MOVED, DVS_START, DST_TMP, J_NONE, PC_FETCH};
        endcase
        return cw;
    endfunction

endpackage

// File: sv/trem_div.sv
`timescale 1ns / 1ps

module trem_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [trem_pkg::DIV_W-1:0]   dividend,
    input  logic [trem_pkg::DIV_W-1:0]   divisor,
    output logic                         busy,
    output logic                         done,
    output logic [trem_pkg::DIV_W-1:0]   quotient
);
    import trem_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   diff;

    // one restoring step: shift in next dividend bit, try subtract
    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[DIV_W]) begin
                rem_reg <= diff[DIV_W-1:0];
            end else begin
                rem_reg <= rem_sh[DIV_W-1:0];
            end
            quo_reg <= {quo_reg[DIV_W-2:0], ~diff[DIV_W]};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/trem_seq.sv
`timescale 1ns / 1ps

module trem_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  trem_pkg::seq_status_t status,
    output trem_pkg::cw_t         cw
);
    import trem_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;

    assign cw = trem_rom(pc_reg);

    always_comb begin
        case (cw.jcond)
            J_NONE:   taken = 1'b0;
            J_ALWAYS: taken = 1'b1;
            J_NOUPD:  taken = status.no_upd;
            J_FIN:    taken = status.fin;
            default:  taken = 1'b0;
        endcase
        pc_next = pc_reg;
        if (status.step_done) begin
            pc_next = taken ? cw.jaddr : pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: sv/transfer_rate_eta_meter_top.sv
`timescale 1ns / 1ps

// Transfer rate and time-left meter.
// Input channel (s_): one transaction per time tick carries now_second and
// byte_position in s_tdata and the ended flag in s_tuser. Every input
// transaction yields exactly one result transaction on the m_ channel:
// bytes_per_second and seconds_left in m_tdata, the updated flag in m_tuser.
// Configuration: cfg_wr_en writes cfg_wdata into total_size (index 0),
// resume_offset (index 1) or start_second (index 2); write only while idle.
// Timing: a microcoded sequencer drives one shared radix-2 divider that
// retires one quotient bit per cycle. An item that updates costs three
// 64-bit divisions, an ended item costs one and an item that does not
// update costs none. One item is in work at a time. The result sits in an
// output register, so the next item is fetched while the previous result
// waits; a stalled receiver holds the sequencer only at its emit step.
// Reset clears configuration, the last-check time and position and the
// held rate and time left to zero and holds s_tready low while aresetn is
// low; no clearing pass.
module transfer_rate_eta_meter_top (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    // input transactions
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // [31:0] now_second, [95:32] byte_position
    input  logic [0:0]   s_tuser,   // [0] ended
    // result transactions
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] bytes_per_second, [127:64] seconds_left
    output logic [0:0]   m_tuser    // [0] updated
);
    import trem_pkg::*;

    cw_t         cw;
    seq_status_t status;

    // configuration
    logic [DIV_W-1:0] total_reg;
    logic [DIV_W-1:0] resume_reg;
    logic [SEC_W-1:0] start_reg;

    // captured item
    logic [SEC_W-1:0] now_reg;
    logic [DIV_W-1:0] pos_reg;
    logic             fin_reg;

    // meter state
    logic [SEC_W-1:0] last_sec_reg;
    logic [DIV_W-1:0] last_bytes_reg;
    logic [DIV_W-1:0] rate_reg;
    logic [DIV_W-1:0] eta_reg;
    logic [DIV_W-1:0] tmp_reg;
    logic             upd_reg;

    // output register
    logic             m_valid_reg;
    logic [DIV_W-1:0] m_rate_reg;
    logic [DIV_W-1:0] m_eta_reg;
    logic             m_upd_reg;

    // divider handshake
    logic             div_armed_reg;
    logic             div_start;
    logic             div_busy;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [DIV_W-1:0] dvd;
    logic [DIV_W-1:0] dvs;

    logic [SEC_W-1:0] since_start;
    logic [SEC_W-1:0] since_check;
    logic [DIV_W-1:0] since_start1;
    logic [DIV_W-1:0] since_check1;
    logic [DIV_W-1:0] avg1;
    logic             s_accept;
    logic             out_free;

    trem_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cw      (cw)
    );

    trem_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_tready = aresetn && (cw.op == OP_FETCH);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // time differences wrap and count unsigned; zero counts as one second
    assign since_start  = now_reg - start_reg;
    assign since_check  = now_reg - last_sec_reg;
    assign since_start1 = (since_start == '0) ? DIV_W'(1) : {{(DIV_W-SEC_W){1'b0}}, since_start};
    assign since_check1 = (since_check == '0) ? DIV_W'(1) : {{(DIV_W-SEC_W){1'b0}}, since_check};
    assign avg1         = (tmp_reg == '0) ? DIV_W'(1) : tmp_reg;

    always_comb begin
        case (cw.dvd)
            DVD_MOVED: dvd = pos_reg - resume_reg;
            DVD_LEFT:  dvd = total_reg - pos_reg;
            DVD_DELTA: dvd = pos_reg - last_bytes_reg;
            default:   dvd = pos_reg - resume_reg;
        endcase
        case (cw.dvs)
            DVS_START: dvs = since_start1;
            DVS_AVG:   dvs = avg1;
            DVS_CHECK: dvs = since_check1;
            default:   dvs = since_start1;
        endcase
    end

    // fire the divider once on entering a divide step
    assign div_start = (cw.op == OP_DIV) && !div_armed_reg;

    always_comb begin
        status.fin    = fin_reg;
        status.no_upd = !fin_reg && !(now_reg > last_sec_reg);
        case (cw.op)
            OP_FETCH:  status.step_done = s_accept;
            OP_TEST:   status.step_done = 1'b1;
            OP_DIV:    status.step_done = div_done;
            OP_FINISH: status.step_done = 1'b1;
            OP_COMMIT: status.step_done = 1'b1;
            OP_EMIT:   status.step_done = out_free;
            default:   status.step_done = 1'b1;
        endcase
    end

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  <= '0;
            resume_reg <= '0;
            start_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TOTAL_SIZE:    total_reg  <= cfg_wdata;
                REG_RESUME_OFFSET: resume_reg <= cfg_wdata;
                REG_START_SECOND:  start_reg  <= cfg_wdata[SEC_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the item
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            now_reg <= s_tdata[SEC_W-1:0];
            pos_reg <= s_tdata[SEC_W+DIV_W-1:SEC_W];
            fin_reg <= s_tuser[0];
        end
    end

    // quotient scratch register
    always_ff @(posedge aclk) begin
        if (cw.op == OP_DIV && div_done && cw.dst == DST_TMP) begin
            tmp_reg <= div_quo;
        end
    end

    // meter state and sequencing flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sec_reg   <= '0;
            last_bytes_reg <= '0;
            rate_reg       <= '0;
            eta_reg        <= '0;
            upd_reg        <= 1'b0;
            div_armed_reg  <= 1'b0;
        end else begin
            if (div_start) begin
                div_armed_reg <= 1'b1;
            end else if (div_done) begin
                div_armed_reg <= 1'b0;
            end
            case (cw.op)
                OP_FETCH: begin
                    upd_reg <= 1'b0;
                end
                OP_DIV: begin
                    if (div_done && cw.dst == DST_ETA) begin
                        eta_reg <= div_quo;
                    end
                    if (div_done && cw.dst == DST_RATE) begin
                        rate_reg <= div_quo;
                    end
                end
                OP_FINISH: begin
                    rate_reg <= tmp_reg;
                    eta_reg  <= '0;
                end
                OP_COMMIT: begin
                    last_sec_reg   <= now_reg;
                    last_bytes_reg <= pos_reg;
                    upd_reg        <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // output register: load at emit, hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cw.op == OP_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cw.op == OP_EMIT && out_free) begin
            m_rate_reg <= rate_reg;
            m_eta_reg  <= eta_reg;
            m_upd_reg  <= upd_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_eta_reg, m_rate_reg};
    assign m_tuser  = m_upd_reg;

`ifndef NO_ASSERTIONS
    // no new item is fetched while a division is still running
    a_fetch_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("item fetched while divider busy");

    // the divider is only started when idle
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // an emit step always leaves a valid result on the output
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.op == OP_EMIT && out_free) |=> m_tvalid)
        else $error("emit did not present a result");

    // an ended update clears the time left
    a_end_eta: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.op == OP_FINISH) |=> (eta_reg == '0))
        else $error("time left not cleared at end");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the transfer rate / time-left meter.
// A driver and a monitor run as clocked always blocks: the driver feeds input
// transactions from a queue that the stimulus block fills, and the monitor
// predicts one result per accepted input and compares it with what comes out.
module tb_top;
    import trem_pkg::*;

    typedef struct packed {
        logic [63:0] rate;
        logic [63:0] eta;
        logic        updated;
    } meter_result_t;

    typedef struct packed {
        logic        ended;
        logic [63:0] pos;
        logic [31:0] now;
    } tick_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0] cfg_index = REG_TOTAL_SIZE;
    logic [63:0]       cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [95:0]       s_tdata   = '0;    // [31:0] now_second, [95:32] byte_position
    logic [0:0]        s_tuser   = '0;    // [0] ended
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [127:0]      m_tdata;           // [63:0] bytes_per_second, [127:64] seconds_left
    logic [0:0]        m_tuser;           // [0] updated

    // register mirror, as the block should hold it
    logic [63:0] total_bytes = '0;
    logic [63:0] resume_pos  = '0;
    logic [31:0] start_sec   = '0;

    // meter state mirror; reset leaves all of it at zero
    logic [31:0] chk_sec   = '0;
    logic [63:0] chk_bytes = '0;
    logic [63:0] rate_held = '0;
    logic [63:0] eta_held  = '0;

    tick_t         pending_q[$];
    meter_result_t want_q[$];

    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked  = 0;
    int unsigned n_upd      = 0;
    int unsigned n_end      = 0;
    int unsigned n_settings = 0;
    int unsigned n_err      = 0;

    logic gaps_on = 1'b1;     // random idling on both sides
    logic s_taken = 1'b0;     // input transaction accepted at the last rising edge

    transfer_rate_eta_meter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] floor_one(input logic [63:0] v);
        return (v == '0) ? 64'd1 : v;
    endfunction

    // Advance the meter state by one input and return the result it yields.
    function automatic meter_result_t meter_predict(input tick_t t);
        logic [63:0]   since_start;
        logic [63:0]   moved;
        logic [63:0]   avg;
        logic [63:0]   since_chk;
        meter_result_t r;
        r.updated = 1'b0;
        // recompute on end, or on a strictly later second than the last check
        if (t.ended || t.now > chk_sec) begin
            // time differences wrap at 32 bits and zero counts as one second
            since_start = floor_one({32'd0, t.now - start_sec});
            moved       = t.pos - resume_pos;
            if (t.ended) begin
                rate_held = moved / since_start;
                eta_held  = '0;
                n_end++;
            end else begin
                avg       = floor_one(moved / since_start);
                eta_held  = (total_bytes - t.pos) / avg;
                since_chk = floor_one({32'd0, t.now - chk_sec});
                rate_held = (t.pos - chk_bytes) / since_chk;
            end
            chk_sec   = t.now;
            chk_bytes = t.pos;
            r.updated = 1'b1;
            n_upd++;
        end
        r.rate = rate_held;
        r.eta  = eta_held;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_err++;
        // keep the log short if everything goes wrong
        if (n_err <= 40)
            $display("mismatch in %s at %0t ns: got %h, want %h", what, $time, got, want);
    endtask

    // Driver: change inputs on the falling edge. Hold the current transaction
    // until it is taken, then load the next one or idle.
    always @(negedge aclk) begin : driver_blk
        tick_t nx;
        if (!s_tvalid || s_taken) begin
            if (pending_q.size() > 0 && !(gaps_on && $urandom_range(99) < 29)) begin
                nx = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nx.pos, nx.now};
                s_tuser  <= nx.ended;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= !(gaps_on && $urandom_range(99) < 29);
    end

    // Monitor: sample on the rising edge. Check a result against the oldest
    // prediction first, then predict for an input taken on the same edge.
    always @(posedge aclk) begin : monitor_blk
        meter_result_t want;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (want_q.size() == 0) begin
                    report_mismatch("result with none pending", m_tdata[63:0], '0);
                end else begin
                    want = want_q.pop_front();
                    n_checked++;
                    if (m_tdata[63:0] !== want.rate)
                        report_mismatch("bytes_per_second", m_tdata[63:0], want.rate);
                    if (m_tdata[127:64] !== want.eta)
                        report_mismatch("seconds_left", m_tdata[127:64], want.eta);
                    if (m_tuser[0] !== want.updated)
                        report_mismatch("updated", {63'd0, m_tuser[0]}, {63'd0, want.updated});
                end
            end
            if (s_tvalid && s_tready) begin
                want_q.push_back(meter_predict(tick_t'({s_tuser[0], s_tdata[95:32],
                                                         s_tdata[31:0]})));
                n_accepted++;
            end
        end
    end

    task automatic push_tick(input logic [31:0] now, input logic [63:0] pos,
                             input logic ended);
        pending_q.push_back('{ended: ended, pos: pos, now: now});
        n_queued++;
    endtask

    // Write one register; the block must be idle.
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_TOTAL_SIZE:    total_bytes = val;
            REG_RESUME_OFFSET: resume_pos  = val;
            REG_START_SECOND:  start_sec   = val[31:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [63:0] tot, input logic [63:0] res,
                                  input logic [31:0] st);
        write_reg(REG_TOTAL_SIZE, tot);
        write_reg(REG_RESUME_OFFSET, res);
        write_reg(REG_START_SECOND, {32'd0, st});
        n_settings++;
    endtask

    // Stall the sender until every queued transaction is in and every result out.
    task automatic wait_drained();
        while (n_accepted != n_queued || want_q.size() != 0) @(negedge aclk);
    endtask

    task automatic randomize_settings();
        logic [63:0] tot;
        logic [63:0] res;
        logic [31:0] st;
        case ($urandom_range(3))
            0: begin
                // ordinary download sizes
                res = $urandom_range(0, 1_000_000);
                tot = res + $urandom_range(0, 2_000_000_000);
                st  = $urandom_range(0, 100_000);
            end
            1: begin
                res = {$urandom, $urandom};
                tot = res + {$urandom_range(0, 255), $urandom};
                st  = $urandom;
            end
            2: begin
                // corners: each register either all zeros or all ones
                res = $urandom_range(1) ? '1 : '0;
                tot = $urandom_range(1) ? '1 : '0;
                st  = $urandom_range(1) ? '1 : '0;
            end
            default: begin
                res = {$urandom, $urandom};
                tot = {$urandom, $urandom};
                st  = $urandom;
            end
        endcase
        apply_settings(tot, res, st);
    endtask

    task automatic push_noise(input logic [31:0] t);
        logic [31:0] nw;
        // either anywhere in time or a few seconds back
        nw = $urandom_range(1) ? 32'($urandom) : t - $urandom_range(0, 5);
        push_tick(nw, {$urandom, $urandom}, 1'($urandom_range(1)));
    endtask

    // One transfer: an end marker rebases the last-check time, then the clock
    // ticks forward by 0..2 seconds while the position mostly grows, and the last
    // step carries ended unless a stray tick takes it. Some stray ticks are mixed in.
    task automatic queue_transfer();
        int unsigned len;
        int unsigned i;
        logic [31:0] t;
        logic [63:0] p;
        len = $urandom_range(8, 60);
        t   = start_sec + $urandom_range(0, 3);
        p   = resume_pos + $urandom_range(0, 100);
        push_tick(t, p, 1'b1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(99) < 12) begin
                push_noise(t);
            end else begin
                t = t + $urandom_range(0, 2);
                case ($urandom_range(19))
                    0:       p = p - $urandom_range(0, 1000);
                    1, 2:    p = p + ({$urandom, $urandom} >> $urandom_range(63));
                    default: p = p + $urandom_range(0, 200_000);
                endcase
                push_tick(t, p, i == len - 1);
            end
        end
    endtask

    initial begin : stimulus_blk
        int unsigned ph;
        int unsigned target;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // registers still at zero after reset
        push_tick(32'd0, 64'd0, 1'b0);        // same second as the last check: hold
        push_tick(32'd0, 64'd0, 1'b1);        // end at the start second: zero elapsed
        push_tick(32'd1, 64'd500, 1'b0);      // remaining bytes wrap below a zero total
        push_tick(32'd1, 64'd900, 1'b0);      // same second again: hold
        wait_drained();

        apply_settings(64'd10000, 64'd1000, 32'd100);
        push_tick(32'd100, 64'd1000, 1'b1);   // end right at start: rate zero
        push_tick(32'd100, 64'd1500, 1'b0);   // equal second: hold
        push_tick(32'd101, 64'd1000, 1'b0);   // nothing moved: zero average
        push_tick(32'd103, 64'd3000, 1'b0);   // plain update
        push_tick(32'd102, 64'd4000, 1'b0);   // clock went back: hold
        push_tick(32'd50, 64'd4000, 1'b1);    // end before start: huge elapsed
        push_tick(32'd104, 64'd500, 1'b0);    // position below resume and last check
        push_tick(32'd106, 64'd20000, 1'b0);  // position past total size
        push_tick(32'd200, 64'd10000, 1'b1);  // normal end
        wait_drained();

        apply_settings('1, '1, '1);
        push_tick('1, '1, 1'b0);              // widest fields, zero since start
        push_tick(32'd0, 64'd0, 1'b1);        // start wraps to one second back
        push_tick('1, 64'd0, 1'b1);
        wait_drained();

        apply_settings('0, '0, '0);
        push_tick(32'd1, '1, 1'b1);           // rebase the last-check second
        push_tick(32'd2, 64'h8000_0000_0000_0000, 1'b0);
        push_tick(32'h8000_0000, 64'h0000_0001_0000_0000, 1'b0);
        wait_drained();

        // random phases; each ends with the sender paused until all results are in
        for (ph = 0; ph < 8; ph++) begin
            randomize_settings();
            gaps_on = (ph != 3);              // one phase runs at full rate
            target  = n_queued + 160;
            while (n_queued < target) queue_transfer();
            wait_drained();
        end

        // let any stray result show up
        repeat (250) @(negedge aclk);
        $display("%0d input transactions, %0d results checked, %0d register settings",
                 n_accepted, n_checked, n_settings);
        $display("%0d recomputed estimates, %0d of them at transfer end, %0d mismatches",
                 n_upd, n_end, n_err);
        if (n_err == 0)
            $display("[transfer_rate_eta_meter_top] OK");
        else
            $display("[transfer_rate_eta_meter_top] ERROR");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog_blk
        #25_000_000;
        $display("timeout: %0d results still pending", want_q.size());
        $display("[transfer_rate_eta_meter_top] ERROR");
        $finish;
    end

endmodule
